// ----- rtl/core/tzpc_pkg.sv -----
// Package for the two-zone passage counter core.
// Holds the transfer payload types, direction codes and sizing constants.
// No dependencies; imported by every module under rtl/core.
package tzpc_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 32;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [15:0] THRESHOLD_RESET = 16'd1500;

    // Direction codes, shared by entry order and last direction.
    typedef enum logic [1:0] {
        DIR_NONE   = 2'd0,
        DIR_A_TO_B = 2'd1,
        DIR_B_TO_A = 2'd2
    } dir_t;

    typedef struct packed {
        logic [15:0] distance_mm;
        logic [31:0] time_ms;
    } tzpc_in_t;

    typedef struct packed {
        logic [15:0] person_count;
        logic [1:0]  last_direction;
        logic        zone_a_busy;
        logic        zone_b_busy;
        logic        any_busy;
    } tzpc_out_t;

    // Classified sample as it sits in the queue.
    typedef struct packed {
        logic        occ;
        logic [31:0] time_ms;
    } tzpc_cls_t;

    // Queue status seen by the front and back sides.
    typedef struct packed {
        logic not_empty;
        logic not_full;
    } tzpc_q_stat_t;

endpackage

// ----- rtl/core/tzpc_front.sv -----
// Front side of the passage counter: threshold register and occupancy classify.
// Depends on tzpc_pkg; feeds tzpc_queue.
module tzpc_front import tzpc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,
    input  logic         s_valid,
    output logic         s_ready,
    input  tzpc_in_t     s_data,
    input  tzpc_q_stat_t q_stat,
    output logic         q_push,
    output tzpc_cls_t    q_entry
);

    logic [15:0] threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            threshold_reg <= cfg_wr_data;
        end
    end

    assign s_ready         = q_stat.not_full;
    assign q_push          = s_valid && q_stat.not_full;
    assign q_entry.occ     = (s_data.distance_mm <= threshold_reg);
    assign q_entry.time_ms = s_data.time_ms;

endmodule

// ----- rtl/core/tzpc_queue.sv -----
// Short FIFO between front and back sides of the passage counter.
// Depends on tzpc_pkg (entry type, depth).
module tzpc_queue import tzpc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  tzpc_cls_t    push_entry,
    input  logic         pop,
    output tzpc_cls_t    head,
    output tzpc_q_stat_t stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tzpc_cls_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head          = slot_reg[rd_ptr_reg];
    assign stat.not_empty = (fill_reg != '0);
    assign stat.not_full  = (fill_reg != CNT_W'(QUEUE_DEPTH));

endmodule

// ----- rtl/core/tzpc_back.sv -----
// Back side of the passage counter: zone state, passage check, count and
// the result register. Depends on tzpc_pkg; pops from tzpc_queue.
module tzpc_back import tzpc_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  tzpc_q_stat_t q_stat,
    input  tzpc_cls_t    q_head,
    output logic         q_pop,
    output logic         m_valid,
    input  logic         m_ready,
    output tzpc_out_t    m_data
);

    logic                   active_reg, active_next;
    logic                   a_occ_reg, a_occ_next;
    logic                   b_occ_reg, b_occ_next;
    logic [TIME_WIDTH-1:0]  a_rise_reg, a_rise_next;
    logic [TIME_WIDTH-1:0]  a_fall_reg, a_fall_next;
    logic [TIME_WIDTH-1:0]  b_rise_reg, b_rise_next;
    logic [TIME_WIDTH-1:0]  b_fall_reg, b_fall_next;
    dir_t                   entry_reg, entry_next;
    dir_t                   dir_reg, dir_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    tzpc_out_t              out_data_reg, out_data_next;

    logic [TIME_WIDTH-1:0]  t_in;
    logic                   changed;
    logic                   both_clear;
    logic                   pass_ab;
    logic                   pass_ba;

    assign q_pop = q_stat.not_empty && (!out_valid_reg || m_ready);
    assign t_in  = TIME_WIDTH'(q_head.time_ms);

    // Zone update from the popped sample.
    always_comb begin
        a_occ_next  = a_occ_reg;
        b_occ_next  = b_occ_reg;
        a_rise_next = a_rise_reg;
        a_fall_next = a_fall_reg;
        b_rise_next = b_rise_reg;
        b_fall_next = b_fall_reg;
        if (!active_reg) begin
            a_occ_next = q_head.occ;
            if (q_head.occ) begin
                a_rise_next = t_in;
            end else begin
                a_fall_next = t_in;
            end
        end else begin
            b_occ_next = q_head.occ;
            if (q_head.occ) begin
                b_rise_next = t_in;
            end else begin
                b_fall_next = t_in;
            end
        end
    end

    assign active_next = ~active_reg;
    assign changed     = (a_occ_next != a_occ_reg) || (b_occ_next != b_occ_reg);
    assign both_clear  = !a_occ_next && !b_occ_next;

    // Full-passage time ordering, checked on the updated times.
    assign pass_ab = (entry_reg == DIR_A_TO_B) && (a_fall_next != '0)
                  && (b_fall_next >= b_rise_next) && (b_fall_next >= a_fall_next)
                  && (b_fall_next >= a_rise_next) && (a_fall_next >= a_rise_next)
                  && (a_fall_next >= b_rise_next) && (b_rise_next >= a_rise_next);
    assign pass_ba = (entry_reg == DIR_B_TO_A) && (a_fall_next != '0)
                  && (a_fall_next >= a_rise_next) && (a_fall_next >= b_fall_next)
                  && (a_fall_next >= b_rise_next) && (b_fall_next >= b_rise_next)
                  && (b_fall_next >= a_rise_next) && (a_rise_next >= b_rise_next);

    always_comb begin
        entry_next = entry_reg;
        dir_next   = dir_reg;
        count_next = count_reg;
        if (changed) begin
            if (a_occ_next && (a_rise_next != '0) && !b_occ_next && (b_rise_next == '0)) begin
                entry_next = DIR_A_TO_B;
            end else if (b_occ_next && (b_rise_next != '0) && !a_occ_next
                         && (a_rise_next == '0)) begin
                entry_next = DIR_B_TO_A;
            end
            if (both_clear) begin
                if (pass_ab) begin
                    dir_next = DIR_A_TO_B;
                    if (count_reg != '1) begin
                        count_next = count_reg + 1'b1;
                    end
                end else if (pass_ba) begin
                    dir_next = DIR_B_TO_A;
                    if (count_reg != '0) begin
                        count_next = count_reg - 1'b1;
                    end
                end
                entry_next = DIR_NONE;
            end
        end
    end

    always_comb begin
        out_data_next.person_count   = 16'(count_next);
        out_data_next.last_direction = dir_next;
        out_data_next.zone_a_busy    = a_occ_next;
        out_data_next.zone_b_busy    = b_occ_next;
        out_data_next.any_busy       = a_occ_next || b_occ_next;
        out_valid_next               = q_pop || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            a_occ_reg     <= 1'b0;
            b_occ_reg     <= 1'b0;
            a_rise_reg    <= '0;
            a_fall_reg    <= '0;
            b_rise_reg    <= '0;
            b_fall_reg    <= '0;
            entry_reg     <= DIR_NONE;
            dir_reg       <= DIR_NONE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (q_pop) begin
                active_reg <= active_next;
                a_occ_reg  <= a_occ_next;
                b_occ_reg  <= b_occ_next;
                entry_reg  <= entry_next;
                dir_reg    <= dir_next;
                count_reg  <= count_next;
                // Times are dropped whenever both zones end up clear.
                if (both_clear) begin
                    a_rise_reg <= '0;
                    a_fall_reg <= '0;
                    b_rise_reg <= '0;
                    b_fall_reg <= '0;
                end else begin
                    a_rise_reg <= a_rise_next;
                    a_fall_reg <= a_fall_next;
                    b_rise_reg <= b_rise_next;
                    b_fall_reg <= b_fall_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ----- rtl/core/two_zone_passage_counter_core.sv -----
// Two-zone passage counter, top level.
// Instantiates tzpc_front, tzpc_queue and tzpc_back; depends on tzpc_pkg.
// Usage:
//  - s_*: one transfer per distance sample (distance_mm, time_ms); samples
//    alternate zone A, zone B, A, ... starting with zone A after reset.
//  - m_*: exactly one result transfer per input transfer, in order: net
//    count, last direction and current zone occupancy.
//  - cfg_wr_en/cfg_wr_data write the occupancy threshold (reset 1500 mm).
//    Write only while no sample is in flight.
// Timing:
//  - m_valid rises once the back stage takes the sample: the queue is written
//    at the accepting edge, and the back stage loads the result register
//    when it pops that entry from the queue.
//  - Throughput is 1 sample per cycle while the receiver keeps m_ready high,
//    set by the back stage's state update.
//  - When the receiver holds m_ready low the result register holds, the
//    2-entry queue fills, and s_ready drops once both entries are taken.
// Reset (aresetn, synchronous, active low) clears zone state, times, count,
// direction and the queue, and loads the default threshold.
module two_zone_passage_counter_core import tzpc_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  tzpc_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output tzpc_out_t   m_data
);

    tzpc_q_stat_t q_stat;
    logic         q_push;
    logic         q_pop;
    tzpc_cls_t    q_entry;
    tzpc_cls_t    q_head;

    // Front: threshold register and sample classify.
    tzpc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    // Decoupling queue.
    tzpc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    // Back: zone tracking, passage check, counting, result register.
    tzpc_back #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_stat  (q_stat),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- rtl/core/tzpc_checker.sv -----
// Port-level checker for the two-zone passage counter core, with its bind.
// Depends on tzpc_pkg and two_zone_passage_counter_core.
module tzpc_checker import tzpc_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input tzpc_out_t m_data
);

    // Result holds while the receiver stalls.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Combined busy flag agrees with the per-zone flags.
    a_any_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.any_busy == (m_data.zone_a_busy || m_data.zone_b_busy)))
        else $error("any_busy mismatch");

    // While no direction has been seen the count is still zero.
    a_dir_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.last_direction == DIR_NONE) |-> (m_data.person_count == '0))
        else $error("count moved without a direction");

    // Nothing is presented right after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid after reset");

endmodule

bind two_zone_passage_counter_core tzpc_checker u_tzpc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- bench/two_zone_passage_counter_core_tb.sv -----
// Self-checking bench for two_zone_passage_counter_core.
// Needs tzpc_pkg and the core RTL. Drives directed, random and stalled traffic
// and checks each result against an in-bench model of the passage counter.
`timescale 1ns / 100ps

module two_zone_passage_counter_core_tb;
    import tzpc_pkg::*;

    localparam logic        ZONE_A      = 1'b0;
    localparam logic        ZONE_B      = 1'b1;
    localparam logic [15:0] COUNT_TOP   = 16'hFFFF;
    localparam logic [15:0] FAR_MM      = 16'hFFFF;
    localparam int          HOLD_CYCLES = 80;
    localparam int          PASS_RUN    = 25;
    localparam longint      RUN_LIMIT_NS = 30_000_000;

    // DUT inputs start at known values
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        s_valid     = 1'b0;
    tzpc_in_t    s_data      = '0;
    logic        m_ready     = 1'b0;
    logic        s_ready;
    logic        m_valid;
    tzpc_out_t   m_data;

    two_zone_passage_counter_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #(RUN_LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Counter model: mirrors the zone state, times, entry order and count.
    // Advanced once per accepted input transfer.
    // ------------------------------------------------------------------
    logic [15:0] thr_model   = THRESHOLD_RESET;
    logic        zone_sel    = ZONE_A;
    logic        a_occ       = 1'b0;
    logic        b_occ       = 1'b0;
    logic [31:0] a_rise      = '0;
    logic [31:0] a_fall      = '0;
    logic [31:0] b_rise      = '0;
    logic [31:0] b_fall      = '0;
    dir_t        entry_dir   = DIR_NONE;
    dir_t        last_dir    = DIR_NONE;
    logic [15:0] count_model = '0;

    tzpc_out_t   expected_counts[$];
    int          fail_count = 0;

    function automatic tzpc_out_t step_zones(tzpc_in_t smp);
        tzpc_out_t r;
        logic      occ;
        logic      was_a;
        logic      was_b;
        occ   = (smp.distance_mm <= thr_model);
        was_a = a_occ;
        was_b = b_occ;
        if (zone_sel == ZONE_A) begin
            a_occ = occ;
            if (occ) a_rise = smp.time_ms;
            else     a_fall = smp.time_ms;
        end else begin
            b_occ = occ;
            if (occ) b_rise = smp.time_ms;
            else     b_fall = smp.time_ms;
        end
        zone_sel = ~zone_sel;

        // entry order and passage check only on an occupancy edge
        if (was_a != a_occ || was_b != b_occ) begin
            if (a_occ && a_rise != 0 && !b_occ && b_rise == 0) begin
                entry_dir = DIR_A_TO_B;
            end else if (b_occ && b_rise != 0 && !a_occ && a_rise == 0) begin
                entry_dir = DIR_B_TO_A;
            end
            if (!a_occ && !b_occ) begin
                if (entry_dir == DIR_A_TO_B && a_fall != 0 &&
                    b_fall >= b_rise && b_fall >= a_fall && b_fall >= a_rise &&
                    a_fall >= a_rise && a_fall >= b_rise && b_rise >= a_rise) begin
                    last_dir = DIR_A_TO_B;
                    if (count_model != COUNT_TOP) count_model = count_model + 1'b1;
                end else if (entry_dir == DIR_B_TO_A && a_fall != 0 &&
                    a_fall >= a_rise && a_fall >= b_fall && a_fall >= b_rise &&
                    b_fall >= b_rise && b_fall >= a_rise && a_rise >= b_rise) begin
                    last_dir = DIR_B_TO_A;
                    if (count_model != 0) count_model = count_model - 1'b1;
                end
                entry_dir = DIR_NONE;
            end
        end

        // times are wiped on every item that leaves both zones clear
        if (!a_occ && !b_occ) begin
            a_rise = '0;
            a_fall = '0;
            b_rise = '0;
            b_fall = '0;
        end

        r.person_count   = count_model;
        r.last_direction = last_dir;
        r.zone_a_busy    = a_occ;
        r.zone_b_busy    = b_occ;
        r.any_busy       = a_occ | b_occ;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every result transfer is matched against the oldest
    // pending expectation.
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        tzpc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_counts.size() == 0) begin
                fail_count++;
                $display("%0t: result with nothing pending, expected none, got %h",
                         $time, m_data);
            end else begin
                want = expected_counts.pop_front();
                check_field("person_count", 32'(want.person_count),
                            32'(m_data.person_count));
                check_field("last_direction", 32'(want.last_direction),
                            32'(m_data.last_direction));
                check_field("zone_a_busy", 32'(want.zone_a_busy), 32'(m_data.zone_a_busy));
                check_field("zone_b_busy", 32'(want.zone_b_busy), 32'(m_data.zone_b_busy));
                check_field("any_busy", 32'(want.any_busy), 32'(m_data.any_busy));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: rotating stall pattern, re-picked when pat_age runs out, with a
    // long hold on request and an always-ready mode for the long run.
    // ------------------------------------------------------------------
    int          hold_req        = 0;
    int          hold_seen       = 0;
    int          hold_left       = 0;
    int          pat_age         = 0;
    logic [15:0] stall_pat       = 16'hFFFF;
    bit          rx_always_ready = 1'b0;

    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (pat_age == 0) begin
            pat_age = 64;
            case ($urandom_range(0, 3))
                0:       stall_pat = 16'hFFFF;                              // no stalls
                1:       stall_pat = 16'($urandom) | 16'h0001;
                2:       stall_pat = ~(16'h0001 << $urandom_range(0, 15));  // lone stall
                default: stall_pat = (16'($urandom) & 16'($urandom)) | 16'h8000;
            endcase
        end
        pat_age--;
        stall_pat = {stall_pat[14:0], stall_pat[15]};
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (rx_always_ready) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= stall_pat[0];
        end
    end

    // ------------------------------------------------------------------
    // Sender side. next_zone tracks which zone the next transfer lands in;
    // zone_dist keeps the last distance per zone for filler samples.
    // ------------------------------------------------------------------
    logic        next_zone    = ZONE_A;
    logic [15:0] zone_dist[2] = '{FAR_MM, FAR_MM};
    logic [31:0] stamp        = '0;
    int          samples_sent = 0;
    bit          gaps_on      = 1'b0;
    int          burst_left   = 0;

    // Offers one sample and returns at the edge where it transfers.
    // The caller either sends again or drops valid in that same step.
    task automatic send_sample(tzpc_in_t smp);
        s_data  <= smp;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_counts.push_back(step_zones(smp));
        zone_dist[next_zone] = smp.distance_mm;
        next_zone = ~next_zone;
        samples_sent++;
    endtask

    // Sender bursts: random length, random gap, some bursts back to back.
    task automatic pace();
        int gap;
        if (!gaps_on) return;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
        burst_left = $urandom_range(1, 24);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Lands a sample in the given zone; a filler sample repeats the other
    // zone's last distance when the alternation is on the wrong zone.
    task automatic put_zone(logic zone, logic [15:0] dist_mm, logic [31:0] t);
        tzpc_in_t smp;
        if (next_zone != zone) begin
            smp.distance_mm = zone_dist[next_zone];
            smp.time_ms     = t;
            send_sample(smp);
            pace();
        end
        smp.distance_mm = dist_mm;
        smp.time_ms     = t;
        send_sample(smp);
        pace();
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_counts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_threshold(logic [15:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        thr_model   = value;
    endtask

    function automatic logic [15:0] pick_distance(logic occ);
        if (occ) begin
            if ($urandom_range(0, 7) == 0) return thr_model;
            return 16'($urandom_range(0, int'(thr_model)));
        end
        if (thr_model == 16'hFFFF) return FAR_MM;  // nothing reads as clear
        if ($urandom_range(0, 7) == 0) return thr_model + 1'b1;
        return 16'($urandom_range(int'(thr_model) + 1, 65535));
    endfunction

    function automatic logic [31:0] next_stamp();
        case ($urandom_range(0, 31))
            0:       stamp = '0;
            1:       stamp = 32'hFFFF_FFFF - $urandom_range(0, 8);
            2:       stamp = $urandom;
            default: stamp = stamp + $urandom_range(0, 4);
        endcase
        return stamp;
    endfunction

    // One walk through both zones with random content; a few are broken
    // (events swapped, last clear dropped) and some carry repeated samples.
    task automatic random_passage();
        logic first;
        logic zone_seq[4];
        logic occ_seq[4];
        logic swap_tmp;
        int   n_events;
        first       = 1'($urandom_range(0, 1));
        zone_seq[0] = first;   occ_seq[0] = 1'b1;
        zone_seq[1] = ~first;  occ_seq[1] = 1'b1;
        zone_seq[2] = first;   occ_seq[2] = 1'b0;
        zone_seq[3] = ~first;  occ_seq[3] = 1'b0;
        if ($urandom_range(0, 7) == 0) begin
            swap_tmp = zone_seq[1]; zone_seq[1] = zone_seq[2]; zone_seq[2] = swap_tmp;
            swap_tmp = occ_seq[1];  occ_seq[1]  = occ_seq[2];  occ_seq[2]  = swap_tmp;
        end
        n_events = ($urandom_range(0, 7) == 0) ? 3 : 4;
        for (int i = 0; i < n_events; i++) begin
            put_zone(zone_seq[i], pick_distance(occ_seq[i]), next_stamp());
            if ($urandom_range(0, 3) == 0)
                put_zone(zone_seq[i], pick_distance(occ_seq[i]), next_stamp());
        end
    endtask

    task automatic random_traffic(int n_items);
        int       start;
        tzpc_in_t smp;
        start = samples_sent;
        while (samples_sent - start < n_items) begin
            if ($urandom_range(0, 4) != 0) begin
                random_passage();
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    smp.distance_mm = 16'($urandom);
                    smp.time_ms     = $urandom;
                    send_sample(smp);
                    pace();
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short hand-built sequence at the default threshold: field extremes,
    // threshold edge, both directions, count floor, zero-time rise.
    task automatic test_directed_passages();
        gaps_on = 1'b0;
        put_zone(ZONE_A, FAR_MM, 32'hFFFF_FFFF);
        put_zone(ZONE_B, THRESHOLD_RESET + 16'd1, 32'd1);
        // A to B, threshold value itself reads as occupied
        put_zone(ZONE_A, THRESHOLD_RESET, 32'd10);
        put_zone(ZONE_B, 16'd0, 32'd11);
        put_zone(ZONE_A, THRESHOLD_RESET + 16'd1, 32'd12);
        put_zone(ZONE_B, FAR_MM, 32'd13);
        // B to A, back down to zero
        put_zone(ZONE_B, 16'd1000, 32'd20);
        put_zone(ZONE_A, 16'd0, 32'd21);
        put_zone(ZONE_B, 16'd2000, 32'd22);
        put_zone(ZONE_A, 16'd3000, 32'd23);
        // B to A at zero: count stays at the floor, direction still updates
        put_zone(ZONE_B, 16'd500, 32'd30);
        put_zone(ZONE_A, 16'd500, 32'd31);
        put_zone(ZONE_B, FAR_MM, 32'd32);
        put_zone(ZONE_A, FAR_MM, 32'd33);
        // rise stamped at zero counts as unset, so no entry order
        put_zone(ZONE_A, 16'd0, 32'd0);
        put_zone(ZONE_B, 16'd0, 32'd1);
        put_zone(ZONE_A, FAR_MM, 32'd2);
        put_zone(ZONE_B, FAR_MM, 32'd3);
        // both clear with no change
        put_zone(ZONE_A, FAR_MM, 32'd4);
        drain_results();
    endtask

    // Receiver holds off while the sender keeps offering; the queue fills
    // and s_ready must drop without losing or duplicating a transfer.
    task automatic test_input_backpressure();
        gaps_on = 1'b0;
        hold_req++;
        repeat (6) random_passage();
        drain_results();
    endtask

    // Random traffic across several thresholds, extremes included.
    task automatic test_threshold_sweep();
        logic [15:0] thr_list[6];
        int          len_list[6];
        thr_list = '{THRESHOLD_RESET, 16'($urandom), 16'd0, 16'hFFFF, 16'd1,
                     16'($urandom_range(100, 4000))};
        len_list = '{150, 130, 120, 50, 130, 170};
        gaps_on = 1'b1;
        foreach (thr_list[i]) begin
            write_threshold(thr_list[i]);
            random_traffic(len_list[i]);
        end
        drain_results();
        gaps_on = 1'b0;
    endtask

    // Full-speed run of A-to-B passages with the receiver always ready,
    // then one B-to-A step down.
    task automatic test_count_run();
        logic [31:0] t;
        write_threshold(THRESHOLD_RESET);
        rx_always_ready = 1'b1;
        t = 32'd1;
        repeat (PASS_RUN) begin
            put_zone(ZONE_A, 16'd0,  t);
            put_zone(ZONE_B, 16'd0,  t + 32'd1);
            put_zone(ZONE_A, FAR_MM, t + 32'd2);
            put_zone(ZONE_B, FAR_MM, t + 32'd3);
            t = t + 32'd4;
        end
        put_zone(ZONE_B, 16'd0,  t);
        put_zone(ZONE_A, 16'd0,  t + 32'd1);
        put_zone(ZONE_B, FAR_MM, t + 32'd2);
        put_zone(ZONE_A, FAR_MM, t + 32'd3);
        drain_results();
        rx_always_ready = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_passages();
        test_input_backpressure();
        test_threshold_sweep();
        test_count_run();
        drain_results();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/tzpc_pkg.sv
rtl/core/tzpc_front.sv
rtl/core/tzpc_queue.sv
rtl/core/tzpc_back.sv
rtl/core/two_zone_passage_counter_core.sv
rtl/core/tzpc_checker.sv
bench/two_zone_passage_counter_core_tb.sv
